@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked
`define GGC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked
`define GGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ggc_pkg.sv @@
package ggc_pkg;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [3:0]  row_index;
		logic [15:0] row_bits;
		logic [3:0]  start_node;
	} item_t;

	typedef struct packed {
		logic [3:0] node;
		logic [4:0] color;
		logic       last;
	} result_t;

endpackage

@@ hw/rtl/ggc_adj_mem.sv @@
module ggc_adj_mem #(
	parameter int NODES = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(NODES)-1:0] waddr,
	input  logic [NODES-1:0]         wdata,
	input  logic [$clog2(NODES)-1:0] raddr,
	output logic [NODES-1:0]         rdata
);

	logic [NODES-1:0] mem [NODES];
	logic [NODES-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ggc_engine.sv @@
module ggc_engine #(
	parameter int NODES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     run_go,
	input  logic [$clog2(NODES)-1:0] start_pivot,
	input  logic [NODES-1:0]         rdata,
	output logic [$clog2(NODES)-1:0] raddr,
	output logic                     busy,
	output logic                     result_valid,
	input  logic                     result_stall,
	output ggc_pkg::result_t         result
);

	localparam int IdxW = $clog2(NODES);
	localparam int ColW = $clog2(NODES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_PIVOT, ST_SCAN, ST_FLUSH} state_t;

	state_t           state_q;
	logic [IdxW-1:0]  cur_q, piv_q, npivot_q, pend_node_q;
	logic [ColW-1:0]  color_q, pend_color_q;
	logic [NODES-1:0] colored_q, members_q, forbid_q;
	logic             found_q, pend_v_q, res_v_q;
	ggc_pkg::result_t res_q;

	logic             out_free, uncol, joins, miss, hold, is_end, more;
	logic [IdxW-1:0]  next_pivot;
	logic [NODES-1:0] cur_bit, piv_bit;

	always_comb begin
		out_free   = !res_v_q || !result_stall;
		cur_bit    = {{(NODES-1){1'b0}}, 1'b1} << cur_q;
		piv_bit    = {{(NODES-1){1'b0}}, 1'b1} << piv_q;
		uncol      = !colored_q[cur_q];
		// both edge directions: pivot/members -> cur via forbid, cur -> class via rdata
		joins      = (state_q == ST_SCAN) && uncol && !forbid_q[cur_q]
			&& ((rdata & members_q) == '0);
		miss       = uncol && !joins;
		hold       = joins && pend_v_q && !out_free;
		is_end     = (cur_q == IdxW'(NODES - 1));
		more       = found_q || miss;
		next_pivot = found_q ? npivot_q : cur_q;
		unique case (state_q)
			ST_IDLE:  raddr = start_pivot;
			ST_PIVOT: raddr = '0;
			ST_SCAN: begin
				if (hold) begin
					raddr = cur_q;
				end else if (is_end) begin
					raddr = next_pivot;
				end else begin
					raddr = cur_q + IdxW'(1);
				end
			end
			ST_FLUSH: raddr = cur_q;
			default:  raddr = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (res_v_q && !result_stall) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (run_go) begin
						colored_q <= '0;
						color_q   <= ColW'(1);
						piv_q     <= start_pivot;
						state_q   <= ST_PIVOT;
					end
				end
				ST_PIVOT: begin
					forbid_q  <= rdata;
					members_q <= piv_bit;
					cur_q     <= '0;
					found_q   <= 1'b0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!hold) begin
						if (joins) begin
							colored_q[cur_q] <= 1'b1;
							members_q        <= members_q | cur_bit;
							forbid_q         <= forbid_q | rdata;
							pend_node_q      <= cur_q;
							pend_color_q     <= color_q;
							pend_v_q         <= 1'b1;
							if (pend_v_q) begin
								res_q.node  <= 4'(pend_node_q);
								res_q.color <= 5'(pend_color_q);
								res_q.last  <= 1'b0;
								res_v_q     <= 1'b1;
							end
						end else if (miss && !found_q) begin
							found_q  <= 1'b1;
							npivot_q <= cur_q;
						end
						if (is_end) begin
							if (more) begin
								piv_q   <= next_pivot;
								color_q <= color_q + ColW'(1);
								state_q <= ST_PIVOT;
							end else begin
								state_q <= ST_FLUSH;
							end
						end else begin
							cur_q <= cur_q + IdxW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						res_q.node  <= 4'(pend_node_q);
						res_q.color <= 5'(pend_color_q);
						res_q.last  <= 1'b1;
						res_v_q     <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule

@@ hw/rtl/greedy_graph_coloring.sv @@
// Greedy graph colouring engine over NODES nodes.
// Input channel (item/item_valid/item_stall): a load beat (kind = load) writes
// one adjacency row; the diagonal and bits beyond NODES are dropped, and a row
// index beyond NODES is ignored. A run beat (kind = run) colours the graph
// starting from start_node (taken modulo NODES).
// Output channel (result/result_valid/result_stall): one beat per coloured
// node in colouring order; the final beat of a run carries last.
// A load beat never raises item_stall. A run holds item_stall high until its
// final beat has been handed to the output register. Each colour round reads
// the pivot row once, then one adjacency row per cycle from the row memory
// while the output does not stall; a run takes at most NODES rounds.
// Results lag the scan by one beat, as the last flag is known only at the end.
// Output stall freezes the scan only when a new beat must be emitted; nothing is lost or repeated.
// Reset clears the control state; rows are undefined until loaded.
module greedy_graph_coloring #(
	parameter int NODES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ggc_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output ggc_pkg::result_t  result
);

	localparam int IdxW = $clog2(NODES);

	logic             accept, load_we, run_go, busy;
	logic [IdxW-1:0]  waddr, raddr, start_pivot;
	logic [NODES-1:0] wdata, rdata;
	logic [4:0]       smod;

	assign item_stall = busy;
	assign accept     = item_valid && !busy;
	assign run_go     = accept && (item.kind == ggc_pkg::KIND_RUN);

	// load beat: drop out-of-range rows, mask the diagonal
	assign load_we = accept && (item.kind == ggc_pkg::KIND_LOAD)
		&& (32'(item.row_index) < 32'(NODES));
	assign waddr   = IdxW'(item.row_index);
	assign wdata   = NODES'(item.row_bits) & ~({{(NODES-1){1'b0}}, 1'b1} << waddr);

	// start node modulo NODES: at most seven subtractions for a 4-bit value
	always_comb begin
		smod = {1'b0, item.start_node};
		for (int k = 0; k < 8; k++) begin
			if (32'(smod) >= 32'(NODES)) begin
				smod = smod - 5'(NODES);
			end
		end
		start_pivot = IdxW'(smod);
	end

	ggc_adj_mem #(
		.NODES (NODES)
	) u_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ggc_engine #(
		.NODES (NODES)
	) u_eng (
		.clk          (clk),
		.arst_n       (arst_n),
		.run_go       (run_go),
		.start_pivot  (start_pivot),
		.rdata        (rdata),
		.raddr        (raddr),
		.busy         (busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ hw/rtl/ggc_checker.sv @@
`include "assert_macros.svh"

module ggc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input ggc_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input ggc_pkg::result_t result
);

	`GGC_ASSERT_NEXT(a_run_busy, clk, arst_n, item_valid && !item_stall && item.kind == ggc_pkg::KIND_RUN, item_stall, "run beat did not raise stall")
	`GGC_ASSERT_SAME(a_busy_cause, clk, arst_n, $rose(item_stall), $past(item_valid && !item_stall && item.kind == ggc_pkg::KIND_RUN), "stall rose without a run beat")
	`GGC_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind greedy_graph_coloring ggc_checker u_chk (.*);
